// ----- sv/scsa_pkg.sv -----
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types and constants of the size-class slot allocator: field widths,
// response status codes, configuration register indexes and opcodes.
// ----------------------------------------------------------------------------
package scsa_pkg;

    // Default geometry of the pools.
    localparam int LEVELS_DEF = 4;
    localparam int SLOTS_DEF  = 256;

    // Number of piece-size registers; no more classes than this are searched.
    localparam int NUM_PIECE  = 4;

    // Fixed field widths of the request and response words.
    localparam int LEN_W      = 20;
    localparam int PIECE_W    = 16;
    localparam int SLOT_W     = 8;
    localparam int FLVL_W     = 3;
    localparam int GLVL_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int LCNT_W     = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [LCNT_W-1:0]  LEVEL_COUNT_RST = 3'd4;
    localparam logic [PIECE_W-1:0] PIECE_0_RST     = 16'd16;
    localparam logic [PIECE_W-1:0] PIECE_1_RST     = 16'd64;
    localparam logic [PIECE_W-1:0] PIECE_2_RST     = 16'd256;
    localparam logic [PIECE_W-1:0] PIECE_3_RST     = 16'd1024;

    // Request opcodes.
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        RS_GRANTED      = 3'd0,
        RS_FALLBACK     = 3'd1,
        RS_ZERO_LEN     = 3'd2,
        RS_FREED        = 3'd3,
        RS_FREE_IGNORED = 3'd4,
        RS_DIRECT_FREED = 3'd5,
        RS_BAD_LEVEL    = 3'd6
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_COUNT = 3'd0,
        CFG_PIECE_0     = 3'd1,
        CFG_PIECE_1     = 3'd2,
        CFG_PIECE_2     = 3'd3,
        CFG_PIECE_3     = 3'd4
    } cfg_reg_t;

endpackage

// ----- sv/scsa_ifs.sv -----
// ----------------------------------------------------------------------------
// scsa_req_if / scsa_rsp_if
// Valid/ready channels of the allocator: request words in, response words out.
// ----------------------------------------------------------------------------

// Request channel: allocate or free.
interface scsa_req_if
    import scsa_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [LEN_W-1:0]  req_length;
    logic [FLVL_W-1:0] free_level;
    logic [SLOT_W-1:0] free_slot;

    modport source (output valid, opcode, req_length, free_level, free_slot,
                    input ready);
    modport sink   (input valid, opcode, req_length, free_level, free_slot,
                    output ready);
endinterface

// Response channel: one word for every request.
interface scsa_rsp_if
    import scsa_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [GLVL_W-1:0]   grant_level;
    logic [SLOT_W-1:0]   grant_slot;
    logic [LEN_W-1:0]    granted_length;

    modport source (output valid, status, grant_level, grant_slot, granted_length,
                    input ready);
    modport sink   (input valid, status, grant_level, grant_slot, granted_length,
                    output ready);
endinterface

// ----- sv/size_class_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// size_class_slot_allocator_unit
// Allocator of fixed-size slots from a set of size classes. Each class keeps
// a FIFO of free slot numbers and an in-use bit per slot, both held in RAM.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake         | word
//  --------+-----+-------------------+-------------------------------------------
//  req     | in  | valid / ready     | opcode, req_length, free_level, free_slot
//  rsp     | out | valid / ready     | status, grant_level, grant_slot, length
//  cfg     | in  | cfg_we, no stall  | cfg_index, cfg_data
//
// A request word is handled in S_IDLE and S_EXEC: the class decision and the RAM reads
// happen on acceptance in S_IDLE, the read-modify-write completes in S_EXEC.
// The split is set by the registered read of the queue and in-use RAMs.
// After reset the in-use RAM is cleared one entry a cycle over its whole depth of
// 2**(LW + SW) entries (1024 at the defaults); req.ready stays low until the pass ends.
// A stalled response holds S_EXEC until the output register frees.
// ----------------------------------------------------------------------------
module size_class_slot_allocator_unit
    import scsa_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF,
    parameter int SLOTS  = SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    scsa_req_if.sink              req,
    scsa_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Geometry: RAM address is {class, position}.
    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AW    = LW + SW;
    localparam int DEPTH = 1 << AW;
    localparam int NSRCH = (LEVELS < NUM_PIECE) ? LEVELS : NUM_PIECE;
    localparam int WIDE  = 13;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    typedef enum logic [2:0] {
        K_GRANT,
        K_FALLBACK,
        K_ZERO,
        K_FREE,
        K_IGNORE,
        K_DIRECT,
        K_BAD
    } kind_t;

    // Configuration registers.
    logic [LCNT_W-1:0]  level_count_reg;
    logic [PIECE_W-1:0] piece_reg [NUM_PIECE];

    // Per-class queue bookkeeping: head, fill, and positions ever written.
    logic [SW-1:0]      head_reg [LEVELS];
    logic [SW:0]        fill_reg [LEVELS];
    logic [SW:0]        wrc_reg  [LEVELS];

    // Control and the request held across S_EXEC.
    state_t             state_reg;
    logic [AW-1:0]      clr_addr_reg;
    kind_t              kind_reg;
    logic [LW-1:0]      cls_reg;
    logic [SW-1:0]      pos_reg;
    logic               written_reg;
    logic [LEN_W-1:0]   len_reg;

    // Output register.
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [GLVL_W-1:0]  out_level_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [LEN_W-1:0]   out_len_reg;

    // Decision signals on acceptance.
    logic               accept;
    logic [NUM_PIECE-1:0] hit;
    logic               found;
    logic [1:0]         sel;
    logic [LW-1:0]      acc_cls;
    kind_t              acc_kind;
    logic [SW-1:0]      acc_pos;
    logic               acc_written;
    logic [LEN_W-1:0]   acc_len;

    // S_EXEC signals.
    logic               done;
    logic               free_ok;
    logic [SW-1:0]      gslot;
    logic [SW:0]        tail_sum;
    logic [SW-1:0]      tail;
    logic [SW-1:0]      head_inc;

    // RAM ports.
    logic [SW-1:0]      q_rdata;
    logic               q_we;
    logic [AW-1:0]      q_waddr;
    logic [AW-1:0]      q_raddr;
    logic [0:0]         u_rdata;
    logic               u_we;
    logic [AW-1:0]      u_waddr;
    logic [0:0]         u_wdata;
    logic [AW-1:0]      u_raddr;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // Class search: first active class whose piece size covers the length.
    always_comb
    begin
        logic [3:0]         sel4;
        logic [3:0]         lvl4;
        logic [WIDE-1:0]    slot_wide;
        hit   = '0;
        found = 1'b0;
        sel   = '0;
        for (int q = 0; q < NUM_PIECE; q++)
        begin
            hit[q] = (q < NSRCH) && (LCNT_W'(q) < level_count_reg)
                     && ({4'b0, piece_reg[q]} >= req.req_length);
        end
        for (int q = 0; q < NUM_PIECE; q++)
        begin
            if (hit[q] && !found)
            begin
                found = 1'b1;
                sel   = 2'(q);
            end
        end
        sel4      = 4'(sel);
        lvl4      = {1'b0, req.free_level};
        slot_wide = WIDE'(req.free_slot);

        acc_kind    = K_FALLBACK;
        acc_cls     = '0;
        acc_pos     = '0;
        acc_written = 1'b0;
        acc_len     = '0;
        if (req.opcode == OP_ALLOC)
        begin
            acc_cls = sel4[LW-1:0];
            acc_pos = head_reg[acc_cls];
            acc_written = ({1'b0, head_reg[acc_cls]} < wrc_reg[acc_cls]);
            if (req.req_length == '0)
            begin
                acc_kind = K_ZERO;
            end
            else if (!found || (fill_reg[acc_cls] == '0))
            begin
                acc_kind = K_FALLBACK;
                acc_len  = req.req_length;
            end
            else
            begin
                acc_kind = K_GRANT;
                acc_len  = LEN_W'(piece_reg[sel]);
            end
        end
        else
        begin
            acc_cls = lvl4[LW-1:0];
            acc_pos = slot_wide[SW-1:0];
            if (lvl4 > 4'(LEVELS))
            begin
                acc_kind = K_BAD;
            end
            else if (lvl4 == 4'(LEVELS))
            begin
                acc_kind = K_DIRECT;
            end
            else if ((slot_wide >= WIDE'(SLOTS))
                     || (fill_reg[acc_cls] >= (SW+1)'(SLOTS)))
            begin
                acc_kind = K_IGNORE;
            end
            else
            begin
                acc_kind = K_FREE;
            end
        end
    end

    // RAM reads are issued on acceptance.
    assign q_raddr = {acc_cls, head_reg[acc_cls]};
    assign u_raddr = {acc_cls, acc_pos};

    // S_EXEC: slot from the queue, tail of the queue, write-back.
    always_comb
    begin
        done     = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);
        free_ok  = (kind_reg == K_FREE) && u_rdata[0];
        // Queue positions never written hold no valid data; the position stands for the slot.
        gslot    = written_reg ? q_rdata : pos_reg;
        tail_sum = {1'b0, head_reg[cls_reg]} + fill_reg[cls_reg];
        if (tail_sum >= (SW+1)'(SLOTS))
        begin
            tail_sum = tail_sum - (SW+1)'(SLOTS);
        end
        tail     = tail_sum[SW-1:0];
        if (head_reg[cls_reg] == SW'(SLOTS - 1))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = head_reg[cls_reg] + SW'(1);
        end
    end

    assign q_we    = done && free_ok;
    assign q_waddr = {cls_reg, tail};

    assign u_we    = (state_reg == S_CLEAR) || (done && ((kind_reg == K_GRANT) || free_ok));
    assign u_waddr = (state_reg == S_CLEAR) ? clr_addr_reg
                   : {cls_reg, (kind_reg == K_GRANT) ? gslot : pos_reg};
    assign u_wdata = 1'((state_reg != S_CLEAR) && (kind_reg == K_GRANT));

    // Free-slot queues of all classes.
    scsa_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (pos_reg),
        .re    (accept),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // In-use bitmaps of all classes.
    scsa_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_in_use_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .re    (accept),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= LEVEL_COUNT_RST;
            piece_reg[0]    <= PIECE_0_RST;
            piece_reg[1]    <= PIECE_1_RST;
            piece_reg[2]    <= PIECE_2_RST;
            piece_reg[3]    <= PIECE_3_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEVEL_COUNT: level_count_reg <= cfg_data[LCNT_W-1:0];
                CFG_PIECE_0:     piece_reg[0]    <= cfg_data;
                CFG_PIECE_1:     piece_reg[1]    <= cfg_data;
                CFG_PIECE_2:     piece_reg[2]    <= cfg_data;
                CFG_PIECE_3:     piece_reg[3]    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Queue heads, fill counts and written-position counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < LEVELS; q++)
            begin
                head_reg[q] <= '0;
                fill_reg[q] <= (SW+1)'(SLOTS);
                wrc_reg[q]  <= '0;
            end
        end
        else if (done)
        begin
            if (kind_reg == K_GRANT)
            begin
                head_reg[cls_reg] <= head_inc;
                fill_reg[cls_reg] <= fill_reg[cls_reg] - (SW+1)'(1);
            end
            else if (free_ok)
            begin
                fill_reg[cls_reg] <= fill_reg[cls_reg] + (SW+1)'(1);
                if (wrc_reg[cls_reg] != (SW+1)'(SLOTS))
                begin
                    wrc_reg[cls_reg] <= wrc_reg[cls_reg] + (SW+1)'(1);
                end
            end
        end
    end

    // Request held for S_EXEC.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= acc_kind;
            cls_reg     <= acc_cls;
            pos_reg     <= acc_pos;
            written_reg <= acc_written;
            len_reg     <= acc_len;
        end
    end

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [3:0]      cls4;
        logic [WIDE-1:0] gslot_wide;
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= RS_GRANTED;
            out_level_reg  <= '0;
            out_slot_reg   <= '0;
            out_len_reg    <= '0;
        end
        else
        begin
            cls4       = 4'(cls_reg);
            gslot_wide = WIDE'(gslot);
            // The word leaves unless a new one is loaded at the same edge.
            if (out_valid_reg && rsp.ready && !done)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (&clr_addr_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (done)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                        // Only a grant carries a class and a slot; the held length is zero for
                        // every free and zero-length word, and a fallback carries the requested length.
                        out_level_reg <= (kind_reg == K_GRANT) ? cls4[GLVL_W-1:0] : '0;
                        out_slot_reg  <= (kind_reg == K_GRANT) ? gslot_wide[SLOT_W-1:0]
                                                               : '0;
                        out_len_reg   <= len_reg;
                        case (kind_reg)
                            K_GRANT:    out_status_reg <= RS_GRANTED;
                            K_FALLBACK: out_status_reg <= RS_FALLBACK;
                            K_ZERO:     out_status_reg <= RS_ZERO_LEN;
                            K_FREE:     out_status_reg <= free_ok ? RS_FREED
                                                                  : RS_FREE_IGNORED;
                            K_IGNORE:   out_status_reg <= RS_FREE_IGNORED;
                            K_DIRECT:   out_status_reg <= RS_DIRECT_FREED;
                            K_BAD:      out_status_reg <= RS_BAD_LEVEL;
                            default:    out_status_reg <= RS_BAD_LEVEL;
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Response word.
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.grant_level    = out_level_reg;
    assign rsp.grant_slot     = out_slot_reg;
    assign rsp.granted_length = out_len_reg;

endmodule

// ----- sv/scsa_ram.sv -----
// ----------------------------------------------------------------------------
// scsa_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
